// ===== design/atscstt_pkg.sv =====
// Shared types, constants and helper functions for the ATSC system time table parser.
// Has no dependencies. Every module of the block imports it.
package atscstt_pkg;

    // Status codes of a finished section.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HEADER    = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_VERSION   = 3'd3;
    localparam logic [2:0] ST_MULTI     = 3'd4;
    localparam logic [2:0] ST_OVERRUN   = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    localparam logic [7:0]  TABLE_ID_RESET = 8'd205;
    localparam logic [11:0] MIN_LENGTH     = 12'd17;
    localparam logic [11:0] DESC_START     = 12'd16;
    localparam logic [11:0] MAX_INDEX      = 12'd4095;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       last_byte;
    } stt_byte_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        first_seen;
        logic        table_changed;
        logic        time_changed;
        logic        offset_changed;
        logic        daylight_changed;
        logic        table_complete;
        logic [31:0] system_time;
        logic [7:0]  gps_utc_offset;
        logic        daylight_saving;
        logic [4:0]  daylight_day;
        logic [7:0]  daylight_hour;
    } stt_result_t;

    // Keep the smallest nonzero error code seen so far.
    function automatic logic [2:0] err_merge(input logic [2:0] cur, input logic [2:0] code);
        if (cur == ST_OK || code < cur)
        begin
            return code;
        end
        return cur;
    endfunction

endpackage

// ===== design/atsc_stt_section_parser.sv =====
// ATSC system time table section parser, top level.
// Depends on atscstt_pkg, atscstt_in_stage, atscstt_parse and atscstt_out_stage.
//
// Usage:
// Section bytes enter on the byte channel (byte_valid/byte_ready) with
// last_byte set on the final byte of each section. One result per section
// leaves on the result channel (result_valid/result_ready); a transfer
// there carries the status, the change flags and the parsed values.
// The byte channel takes one byte per cycle for as long as the receiver keeps
// up. A byte is registered on its transfer and parsed in the next cycle; the
// result of a section is registered in the result register as its last byte is consumed.
// If the receiver stalls, the result register holds its result; bytes that
// do not end a section keep flowing, and only a further section end waits
// in the input register until the result register frees up.
// The expected table id is written through cfg_wr_en/cfg_wr_data at any
// edge; it should be changed only while no section is in flight.
// Reset clears all section state and the stored table values and loads
// the expected table id with 0xCD.
module atsc_stt_section_parser
    import atscstt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  section_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic        first_seen,
    output logic        table_changed,
    output logic        time_changed,
    output logic        offset_changed,
    output logic        daylight_changed,
    output logic        table_complete,
    output logic [31:0] system_time,
    output logic [7:0]  gps_utc_offset,
    output logic        daylight_saving,
    output logic [4:0]  daylight_day,
    output logic [7:0]  daylight_hour
);

    stt_byte_t   byte_in;
    stt_byte_t   held_byte;
    logic        held_valid;
    logic        consume;
    logic        out_free;
    logic        result_load;
    stt_result_t result_next;
    stt_result_t result_out;

    assign byte_in.section_byte = section_byte;
    assign byte_in.last_byte    = last_byte;

    atscstt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_in    (byte_in),
        .consume    (consume),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    atscstt_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .held_valid  (held_valid),
        .held_byte   (held_byte),
        .out_free    (out_free),
        .consume     (consume),
        .result_load (result_load),
        .result_next (result_next)
    );

    atscstt_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_load  (result_load),
        .result_next  (result_next),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_out   (result_out)
    );

    assign status           = result_out.status;
    assign first_seen       = result_out.first_seen;
    assign table_changed    = result_out.table_changed;
    assign time_changed     = result_out.time_changed;
    assign offset_changed   = result_out.offset_changed;
    assign daylight_changed = result_out.daylight_changed;
    assign table_complete   = result_out.table_complete;
    assign system_time      = result_out.system_time;
    assign gps_utc_offset   = result_out.gps_utc_offset;
    assign daylight_saving  = result_out.daylight_saving;
    assign daylight_day     = result_out.daylight_day;
    assign daylight_hour    = result_out.daylight_hour;

endmodule

// ===== design/atscstt_in_stage.sv =====
// Input register of the section parser: holds one section byte until it is processed.
// Depends on atscstt_pkg.
module atscstt_in_stage
    import atscstt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  stt_byte_t byte_in,
    input  logic      consume,
    output logic      held_valid,
    output stt_byte_t held_byte
);

    logic      valid_reg;
    logic      valid_next;
    stt_byte_t data_reg;

    // The register can refill in the same cycle its byte is consumed.
    assign byte_ready = !valid_reg || consume;
    assign held_valid = valid_reg;
    assign held_byte  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_ready)
        begin
            valid_next = byte_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            data_reg <= byte_in;
        end
    end

endmodule

// ===== design/atscstt_parse.sv =====
// Section state and per-byte parsing logic, plus the stored table values.
// Depends on atscstt_pkg.
module atscstt_parse
    import atscstt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        held_valid,
    input  stt_byte_t   held_byte,
    input  logic        out_free,
    output logic        consume,
    output logic        result_load,
    output stt_result_t result_next
);

    logic [7:0]  table_id_reg;
    logic [11:0] byte_index_reg, byte_index_next;
    logic [11:0] length_reg, length_next;
    logic [12:0] desc_pos_reg, desc_pos_next;
    logic [2:0]  error_reg, error_next;
    logic [31:0] new_time_reg, new_time_next;
    logic [7:0]  new_offset_reg, new_offset_next;
    logic [7:0]  new_dl_reg, new_dl_next;
    logic [7:0]  new_hour_reg, new_hour_next;
    logic [31:0] stored_time_reg;
    logic [7:0]  stored_offset_reg;
    logic        stored_daylight_reg;
    logic [4:0]  stored_day_reg;
    logic [7:0]  stored_hour_reg;

    logic [7:0]  b;
    logic [11:0] pos;
    logic [11:0] crc_pos;
    logic [13:0] desc_len_pos;
    logic [13:0] desc_end;
    logic [2:0]  status;
    logic        tc, oc, dc, any_change, first;

    // A byte that ends a section needs room in the result register.
    assign consume     = held_valid && (!held_byte.last_byte || out_free);
    assign result_load = consume && held_byte.last_byte;

    always_comb
    begin
        b               = held_byte.section_byte;
        pos             = byte_index_reg;
        length_next     = length_reg;
        desc_pos_next   = desc_pos_reg;
        error_next      = error_reg;
        new_time_next   = new_time_reg;
        new_offset_next = new_offset_reg;
        new_dl_next     = new_dl_reg;
        new_hour_next   = new_hour_reg;

        case (pos)
            12'd0:
            begin
                if (b != table_id_reg)
                begin
                    error_next = err_merge(error_next, ST_HEADER);
                end
            end
            12'd1:
            begin
                if (!b[7] || !b[6])
                begin
                    error_next = err_merge(error_next, ST_HEADER);
                end
                length_next = {b[3:0], 8'h00};
            end
            12'd2:
            begin
                length_next = {length_reg[11:8], b};
                if ({length_reg[11:8], b} < MIN_LENGTH)
                begin
                    error_next = err_merge(error_next, ST_SHORT);
                end
            end
            12'd5:
            begin
                if (!b[0])
                begin
                    error_next = err_merge(error_next, ST_HEADER);
                end
            end
            12'd6, 12'd7:
            begin
                if (b != 8'h00)
                begin
                    error_next = err_merge(error_next, ST_MULTI);
                end
            end
            12'd8:
            begin
                if (b != 8'h00)
                begin
                    error_next = err_merge(error_next, ST_VERSION);
                end
            end
            12'd9, 12'd10, 12'd11, 12'd12:
            begin
                new_time_next = {new_time_reg[23:0], b};
            end
            12'd13:  new_offset_next = b;
            12'd14:  new_dl_next     = b;
            12'd15:  new_hour_next   = b;
            default: ;
        endcase

        // Descriptor walk: on the length byte of a descriptor, check that it
        // stays ahead of the first CRC byte.
        crc_pos      = length_reg - 12'd1;
        desc_len_pos = {1'b0, desc_pos_reg} + 14'd1;
        desc_end     = {1'b0, desc_pos_reg} + 14'd2 + {6'd0, b};
        if (pos >= DESC_START && length_reg >= MIN_LENGTH)
        begin
            if (desc_len_pos < {2'b00, crc_pos} && {2'b00, pos} == desc_len_pos)
            begin
                if (desc_end > {2'b00, crc_pos})
                begin
                    error_next = err_merge(error_next, ST_OVERRUN);
                end
                else
                begin
                    desc_pos_next = desc_end[12:0];
                end
            end
        end

        byte_index_next = (pos < MAX_INDEX) ? pos + 12'd1 : MAX_INDEX;

        status = error_next;
        if (status == ST_OK && {1'b0, byte_index_next} < {1'b0, length_next} + 13'd3)
        begin
            status = ST_TRUNCATED;
        end

        tc = new_time_next != stored_time_reg;
        oc = new_offset_next != stored_offset_reg;
        dc = (new_dl_next[7] != stored_daylight_reg) ||
             (new_dl_next[4:0] != stored_day_reg) ||
             (new_hour_next != stored_hour_reg);
        any_change = tc || oc || dc;
        first      = tc && (stored_time_reg == 32'd0);

        result_next        = '0;
        result_next.status = status;
        if (status == ST_OK)
        begin
            result_next.first_seen       = first;
            result_next.table_changed    = any_change && !first;
            result_next.time_changed     = tc;
            result_next.offset_changed   = oc;
            result_next.daylight_changed = dc;
            result_next.table_complete   = any_change;
            result_next.system_time      = new_time_next;
            result_next.gps_utc_offset   = new_offset_next;
            result_next.daylight_saving  = new_dl_next[7];
            result_next.daylight_day     = new_dl_next[4:0];
            result_next.daylight_hour    = new_hour_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_id_reg        <= TABLE_ID_RESET;
            byte_index_reg      <= '0;
            length_reg          <= '0;
            desc_pos_reg        <= {1'b0, DESC_START};
            error_reg           <= ST_OK;
            new_time_reg        <= '0;
            new_offset_reg      <= '0;
            new_dl_reg          <= '0;
            new_hour_reg        <= '0;
            stored_time_reg     <= '0;
            stored_offset_reg   <= '0;
            stored_daylight_reg <= 1'b0;
            stored_day_reg      <= '0;
            stored_hour_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_id_reg <= cfg_wr_data;
            end
            if (consume)
            begin
                if (held_byte.last_byte)
                begin
                    // End of section: start the next one from a clean state.
                    byte_index_reg <= '0;
                    length_reg     <= '0;
                    desc_pos_reg   <= {1'b0, DESC_START};
                    error_reg      <= ST_OK;
                    new_time_reg   <= '0;
                    new_offset_reg <= '0;
                    new_dl_reg     <= '0;
                    new_hour_reg   <= '0;
                    if (status == ST_OK)
                    begin
                        stored_time_reg     <= new_time_next;
                        stored_offset_reg   <= new_offset_next;
                        stored_daylight_reg <= new_dl_next[7];
                        stored_day_reg      <= new_dl_next[4:0];
                        stored_hour_reg     <= new_hour_next;
                    end
                end
                else
                begin
                    byte_index_reg <= byte_index_next;
                    length_reg     <= length_next;
                    desc_pos_reg   <= desc_pos_next;
                    error_reg      <= error_next;
                    new_time_reg   <= new_time_next;
                    new_offset_reg <= new_offset_next;
                    new_dl_reg     <= new_dl_next;
                    new_hour_reg   <= new_hour_next;
                end
            end
        end
    end

endmodule

// ===== design/atscstt_out_stage.sv =====
// Result register of the section parser: holds one result until the receiver takes it.
// Depends on atscstt_pkg.
module atscstt_out_stage
    import atscstt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_load,
    input  stt_result_t result_next,
    output logic        out_free,
    output logic        result_valid,
    input  logic        result_ready,
    output stt_result_t result_out
);

    logic        valid_reg;
    logic        valid_next;
    stt_result_t data_reg;

    assign out_free     = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result_out   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            data_reg <= result_next;
        end
    end

endmodule
